// ----- src/assert_macros.svh -----
// assertion macros shared by the access filter rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/rif_pkg.sv -----
// shared types, codes and constants for the radio id access filter
// no dependencies; imported by every module of the block
package rif_pkg;

  localparam int DEF_LIST_DEPTH = 64;
  localparam int NUM_LISTS      = 5;
  localparam int ID_W           = 24;
  localparam int OWN_W          = 30;
  localparam int CFG_IDX_W      = 2;
  localparam int PROD_W         = 2 * OWN_W;
  localparam int PREFIX_W       = 11;

  // commands
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_CHECK  = 2'd2;

  // list selects
  localparam logic [2:0] SEL_BLOCKED  = 3'd0;
  localparam logic [2:0] SEL_ALLOWED  = 3'd1;
  localparam logic [2:0] SEL_PREFIX   = 3'd2;
  localparam logic [2:0] SEL_SLOT_ONE = 3'd3;
  localparam logic [2:0] SEL_SLOT_TWO = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_ONLY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID    = 2'd1;

  // own id digit limits
  localparam logic [OWN_W-1:0] OWN_NINE_DIGITS  = 30'd99999999;
  localparam logic [OWN_W-1:0] OWN_EIGHT_DIGITS = 30'd9999999;

  // reciprocals for division by constants, exact over the operand ranges
  localparam logic [OWN_W-1:0] RECIP_100   = 30'd687194768;
  localparam int               SHIFT_100   = 36;
  localparam logic [OWN_W-1:0] RECIP_10    = 30'd858993460;
  localparam int               SHIFT_10    = 33;
  localparam logic [OWN_W-1:0] RECIP_10000 = 30'd13743896;
  localparam int               SHIFT_10000 = 37;

  localparam logic [PREFIX_W-1:0] PREFIX_MAX = 11'd999;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_MUL_OWN,
    ST_MUL_SRC,
    ST_QUOT,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic apply;
    logic mul_own;
    logic mul_src;
    logic quot;
    logic scan_en;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_check;
    logic scan_last;
  } dp_status_t;

endpackage

// ----- src/radio_id_access_filter_core.sv -----
// access filter for radio source ids and talkgroups over five loaded lists
// check: the result follows a lockstep walk of the list memories through one read port each
// clear and append skip the walk; one item in flight, the next is taken only after its result is loaded
// reset: synchronous, clears list counts and configuration; entries stay unwritten
// uses rif_pkg, rif_ctrl, rif_datapath, rif_list_mem and assert_macros.svh
module radio_id_access_filter_core import rif_pkg::*; #(
  parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           command,
  input  logic [2:0]           list_select,
  input  logic [ID_W-1:0]      entry_value,
  input  logic [ID_W-1:0]      src_id,
  input  logic [ID_W-1:0]      dest_id,
  input  logic [1:0]           slot,
  input  logic                 group_call,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 check_done,
  output logic                 source_ok,
  output logic                 dest_ok,
  output logic                 list_full,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [OWN_W-1:0]     cfg_data
);

  `include "assert_macros.svh"

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  rif_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  rif_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .command     (command),
    .list_select (list_select),
    .entry_value (entry_value),
    .src_id      (src_id),
    .dest_id     (dest_id),
    .slot        (slot),
    .group_call  (group_call),
    .check_done  (check_done),
    .source_ok   (source_ok),
    .dest_ok     (dest_ok),
    .list_full   (list_full)
  );

  `ASSERT_ALWAYS(a_no_verdict_off_check, clk, rst, !(out_valid && !check_done) || (!source_ok && !dest_ok), "verdict bits set on a non-check beat")
  `ASSERT_ALWAYS(a_no_full_on_check, clk, rst, !(out_valid && check_done) || !list_full, "list_full set on a check beat")
  `ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready, "input taken while an item is in flight")

endmodule

// ----- src/rif_list_mem.sv -----
// one identifier list: single write port, single registered read port
// uses rif_pkg for the entry width
module rif_list_mem import rif_pkg::*; #(
  parameter int DEPTH = DEF_LIST_DEPTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  logic [ID_W-1:0] wdata,
  input  logic [AW-1:0]   raddr,
  output logic [ID_W-1:0] rdata
);

  logic [ID_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- src/rif_ctrl.sv -----
// sequencing state machine of the access filter
// uses rif_pkg for state and command types; drives the datapath
module rif_ctrl import rif_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_valid) state_next = ST_APPLY;
      ST_APPLY:   state_next = status.is_check ? ST_MUL_OWN : ST_FINISH;
      ST_MUL_OWN: state_next = ST_MUL_SRC;
      ST_MUL_SRC: state_next = ST_QUOT;
      ST_QUOT:    state_next = ST_SCAN;
      ST_SCAN:    if (status.scan_last) state_next = ST_DRAIN;
      ST_DRAIN:   state_next = ST_FINISH;
      ST_FINISH:  if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_APPLY:   cmd.apply   = 1'b1;
      ST_MUL_OWN: cmd.mul_own = 1'b1;
      ST_MUL_SRC: cmd.mul_src = 1'b1;
      ST_QUOT:    cmd.quot    = 1'b1;
      ST_SCAN:    cmd.scan_en = 1'b1;
      ST_FINISH:  cmd.load_out = out_free;
      default:    cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- src/rif_datapath.sv -----
// item registers, lists, shared multiplier, scan compare and result register
// uses rif_pkg and rif_list_mem; commanded by rif_ctrl
module rif_datapath import rif_pkg::*; #(
  parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [OWN_W-1:0]     cfg_data,
  input  logic [1:0]           command,
  input  logic [2:0]           list_select,
  input  logic [ID_W-1:0]      entry_value,
  input  logic [ID_W-1:0]      src_id,
  input  logic [ID_W-1:0]      dest_id,
  input  logic [1:0]           slot,
  input  logic                 group_call,
  output logic                 check_done,
  output logic                 source_ok,
  output logic                 dest_ok,
  output logic                 list_full
);

  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  // configuration
  logic             self_only_r;
  logic [OWN_W-1:0] own_id_r;

  // captured item
  logic [1:0]      cmd_r;
  logic [2:0]      sel_r;
  logic [ID_W-1:0] entry_r;
  logic [ID_W-1:0] src_r;
  logic [ID_W-1:0] dest_r;
  logic [1:0]      slot_r;
  logic            group_r;

  logic [CNT_W-1:0]    counts [NUM_LISTS];
  logic                full_r;
  logic [PROD_W-1:0]   prod;
  logic [OWN_W-1:0]    mul_a, mul_b;
  logic [OWN_W-1:0]    own_q;
  logic [PREFIX_W-1:0] prefix;
  logic [IDX_W-1:0]    idx, cmp_idx;
  logic                cmp_en;
  logic [NUM_LISTS-1:0] hit;
  logic [NUM_LISTS-1:0] we;
  logic [ID_W-1:0]     rdata [NUM_LISTS];
  logic [ID_W-1:0]     key   [NUM_LISTS];
  logic                is_append, full_next;
  logic                src_ok_lists, src_ok, dst_ok, grp_hit, grp_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      self_only_r <= 1'b0;
      own_id_r    <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SELF_ONLY) self_only_r <= cfg_data[0];
      if (cfg_index == CFG_OWN_ID)    own_id_r    <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= command;
      sel_r   <= list_select;
      entry_r <= entry_value;
      src_r   <= src_id;
      dest_r  <= dest_id;
      slot_r  <= slot;
      group_r <= group_call;
    end
  end

  assign is_append = (cmd_r == CMD_APPEND) && (sel_r < 3'(NUM_LISTS));

  always_comb begin
    full_next = 1'b0;
    for (int l = 0; l < NUM_LISTS; l++) begin
      we[l] = 1'b0;
      if (is_append && sel_r == 3'(l)) begin
        if (counts[l] >= CNT_W'(LIST_DEPTH)) full_next = 1'b1;
        else we[l] = cmd.apply;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < NUM_LISTS; l++) counts[l] <= '0;
    end else if (cmd.apply) begin
      for (int l = 0; l < NUM_LISTS; l++) begin
        if (cmd_r == CMD_CLEAR) counts[l] <= '0;
        else if (we[l]) counts[l] <= counts[l] + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) full_r <= full_next;
  end

  // shared multiplier: own id reciprocal first, then source by 10000
  always_comb begin
    if (cmd.mul_own) begin
      mul_a = own_id_r;
      mul_b = (own_id_r > OWN_NINE_DIGITS) ? RECIP_100 : RECIP_10;
    end else begin
      mul_a = OWN_W'(src_r);
      mul_b = RECIP_10000;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_own || cmd.mul_src) prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_src) begin
      if (own_id_r > OWN_NINE_DIGITS)
        own_q <= OWN_W'(prod >> SHIFT_100);
      else if (own_id_r > OWN_EIGHT_DIGITS)
        own_q <= OWN_W'(prod >> SHIFT_10);
      else
        own_q <= own_id_r;
    end
    if (cmd.quot) prefix <= PREFIX_W'(prod >> SHIFT_10000);
  end

  // scan walks all entries in lockstep, entries at or above a count are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en <= 1'b0;
    end else begin
      cmp_en <= cmd.scan_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.quot) idx <= '0;
    else if (cmd.scan_en) idx <= idx + IDX_W'(1);
    cmp_idx <= idx;
  end

  assign status.scan_last = (idx == IDX_W'(LIST_DEPTH - 1));
  assign status.is_check  = (cmd_r == CMD_CHECK);

  always_comb begin
    key[SEL_BLOCKED]  = src_r;
    key[SEL_ALLOWED]  = src_r;
    key[SEL_PREFIX]   = ID_W'(prefix);
    key[SEL_SLOT_ONE] = dest_r;
    key[SEL_SLOT_TWO] = dest_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.quot) begin
      hit <= '0;
    end else if (cmp_en) begin
      for (int l = 0; l < NUM_LISTS; l++) begin
        if (CNT_W'(cmp_idx) < counts[l] && rdata[l] == key[l]) hit[l] <= 1'b1;
      end
    end
  end

  for (genvar g = 0; g < NUM_LISTS; g++) begin : g_list
    rif_list_mem #(
      .DEPTH (LIST_DEPTH),
      .AW    (IDX_W)
    ) u_mem (
      .clk   (clk),
      .we    (we[g]),
      .waddr (counts[g][IDX_W-1:0]),
      .wdata (entry_r),
      .raddr (idx),
      .rdata (rdata[g])
    );
  end

  always_comb begin
    src_ok_lists = !hit[SEL_BLOCKED]
                && (prefix != '0) && (prefix <= PREFIX_MAX)
                && ((counts[SEL_PREFIX] == '0) || hit[SEL_PREFIX])
                && ((counts[SEL_ALLOWED] == '0) || hit[SEL_ALLOWED]);
    src_ok    = self_only_r ? (OWN_W'(src_r) == own_q) : src_ok_lists;
    grp_hit   = (slot_r == 2'd1) ? hit[SEL_SLOT_ONE] : hit[SEL_SLOT_TWO];
    grp_empty = (slot_r == 2'd1) ? (counts[SEL_SLOT_ONE] == '0)
                                 : (counts[SEL_SLOT_TWO] == '0);
    dst_ok    = !group_r || ((dest_r != '0) && (grp_empty || grp_hit));
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      check_done <= status.is_check;
      source_ok  <= status.is_check && src_ok;
      dest_ok    <= status.is_check && dst_ok;
      list_full  <= full_r;
    end
  end

endmodule

// ----- bench/rif_decision_checker.sv -----
// checker for radio_id_access_filter_core: watches the config, item and result channels,
// keeps its own copy of the five id lists and the registers, and compares every result beat
// depends on rif_pkg only
module rif_decision_checker import rif_pkg::*; #(
  parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [1:0]           command,
  input  logic [2:0]           list_select,
  input  logic [ID_W-1:0]      entry_value,
  input  logic [ID_W-1:0]      src_id,
  input  logic [ID_W-1:0]      dest_id,
  input  logic [1:0]           slot,
  input  logic                 group_call,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 check_done,
  input  logic                 source_ok,
  input  logic                 dest_ok,
  input  logic                 list_full,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [OWN_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PREFIX_DIV = 10000;

  typedef struct packed {
    logic check_done;
    logic source_ok;
    logic dest_ok;
    logic list_full;
  } verdict_t;

  logic [ID_W-1:0]  id_lists [NUM_LISTS][LIST_DEPTH];
  int unsigned      list_len [NUM_LISTS];
  logic             self_only_q = 1'b0;
  logic [OWN_W-1:0] own_id_q = '0;
  verdict_t         expected_verdicts [$];

  initial mismatches = 0;
  initial pending = 0;

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_bit(string field, logic got, logic want);
    if (got !== want)
      report_mismatch($sformatf("%s is %b, predicted %b", field, got, want));
  endtask

  // only entries below the count are ever looked at
  function automatic bit list_holds(logic [2:0] sel, logic [ID_W-1:0] value);
    for (int i = 0; i < list_len[sel]; i++)
      if (id_lists[sel][i] == value) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit source_admitted_now(logic [ID_W-1:0] src);
    logic [OWN_W-1:0] own_cut;
    int unsigned prefix;
    if (self_only_q) begin
      // drop one or two suffix digits from a long own id
      if (own_id_q > OWN_NINE_DIGITS) own_cut = OWN_W'(own_id_q / 100);
      else if (own_id_q > OWN_EIGHT_DIGITS) own_cut = OWN_W'(own_id_q / 10);
      else own_cut = own_id_q;
      return {{(OWN_W-ID_W){1'b0}}, src} == own_cut;
    end
    if (list_holds(SEL_BLOCKED, src)) return 1'b0;
    prefix = src / PREFIX_DIV;
    if (prefix == 0 || prefix > PREFIX_MAX) return 1'b0;
    if (list_len[SEL_PREFIX] != 0 && !list_holds(SEL_PREFIX, prefix[ID_W-1:0])) return 1'b0;
    if (list_len[SEL_ALLOWED] != 0) return list_holds(SEL_ALLOWED, src);
    return 1'b1;
  endfunction

  function automatic bit dest_admitted_now(logic [1:0] slot_v, logic grp,
                                           logic [ID_W-1:0] dest);
    logic [2:0] sel;
    sel = (slot_v == 2'd1) ? SEL_SLOT_ONE : SEL_SLOT_TWO;
    if (!grp) return 1'b1;
    if (dest == '0) return 1'b0;
    if (list_len[sel] == 0) return 1'b1;
    return list_holds(sel, dest);
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    verdict_t got;
    if (rst) begin
      foreach (list_len[i]) list_len[i] = 0;
      self_only_q = 1'b0;
      own_id_q = '0;
      expected_verdicts.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SELF_ONLY: self_only_q = cfg_data[0];
          CFG_OWN_ID:    own_id_q = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = '0;
        case (command)
          CMD_CLEAR: begin
            foreach (list_len[i]) list_len[i] = 0;
          end
          CMD_APPEND: begin
            if (list_select < NUM_LISTS) begin
              if (list_len[list_select] >= LIST_DEPTH) begin
                want.list_full = 1'b1;
              end else begin
                id_lists[list_select][list_len[list_select]] = entry_value;
                list_len[list_select]++;
              end
            end
          end
          CMD_CHECK: begin
            want.check_done = 1'b1;
            want.source_ok = source_admitted_now(src_id);
            want.dest_ok = dest_admitted_now(slot, group_call, dest_id);
          end
          default: ;
        endcase
        expected_verdicts.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = {check_done, source_ok, dest_ok, list_full};
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("result beat %b with nothing predicted", got));
        end else begin
          want = expected_verdicts.pop_front();
          compare_bit("check_done", got.check_done, want.check_done);
          compare_bit("source_ok", got.source_ok, want.source_ok);
          compare_bit("dest_ok", got.dest_ok, want.dest_ok);
          compare_bit("list_full", got.list_full, want.list_full);
        end
      end
    end
    pending = expected_verdicts.size();
  end

endmodule

// ----- bench/tb.sv -----
// top of the radio_id_access_filter_core bench: clock, reset, list loads, id checks and
// register writes under varying idle and stall patterns; verdict from rif_decision_checker
// depends on rif_pkg, rif_decision_checker and the block's rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rif_pkg::*;

  localparam int LIST_DEPTH  = DEF_LIST_DEPTH;
  localparam int CLK_PERIOD  = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int BLOCKS      = 8;
  localparam int BLOCK_ITEMS = 125;
  // command code with no effect on the lists; the block still returns a result beat
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           command = CMD_CLEAR;
  logic [2:0]           list_select = SEL_BLOCKED;
  logic [ID_W-1:0]      entry_value = '0;
  logic [ID_W-1:0]      src_id = '0;
  logic [ID_W-1:0]      dest_id = '0;
  logic [1:0]           slot = 2'd1;
  logic                 group_call = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 check_done;
  logic                 source_ok;
  logic                 dest_ok;
  logic                 list_full;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SELF_ONLY;
  logic [OWN_W-1:0]     cfg_data = '0;
  int                   mismatches;
  int                   pending;

  int unsigned          send_idle_pct = 0;
  int unsigned          stall_pct = 0;
  int unsigned          cycle_count = 0;
  logic                 cur_self = 1'b0;
  logic [OWN_W-1:0]     cur_own = '0;
  // values loaded into each list, used to aim checks at hits
  logic [ID_W-1:0]      loaded [NUM_LISTS][$];

  radio_id_access_filter_core #(.LIST_DEPTH(LIST_DEPTH)) u_dut (.*);
  rif_decision_checker #(.LIST_DEPTH(LIST_DEPTH)) u_checker (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("radio_id_access_filter_core regression: fail");
      $finish;
    end
  end

  function automatic logic [ID_W-1:0] rand_id24();
    logic [ID_W-1:0] v;
    v = ID_W'($urandom());
    return v;
  endfunction

  // five to seven digit id with a prefix in the legal range
  function automatic logic [ID_W-1:0] rand_radio_id();
    return ID_W'($urandom_range(999, 1) * 10000 + $urandom_range(9999));
  endfunction

  function automatic logic [ID_W-1:0] rand_group();
    if ($urandom_range(3) == 0) return rand_id24();
    return ID_W'($urandom_range(9999, 1));
  endfunction

  function automatic logic [ID_W-1:0] pick_loaded(logic [2:0] sel,
                                                  logic [ID_W-1:0] fallback);
    if (loaded[sel].size() == 0) return fallback;
    return loaded[sel][$urandom_range(loaded[sel].size() - 1)];
  endfunction

  function automatic logic [ID_W-1:0] gen_entry(logic [2:0] sel);
    if ($urandom_range(7) == 0) return rand_id24();
    case (sel)
      SEL_BLOCKED, SEL_ALLOWED: return rand_radio_id();
      SEL_PREFIX:               return ID_W'($urandom_range(999, 1));
      default:                  return rand_group();
    endcase
  endfunction

  // sources near the own id with zero, one or two digits cut
  function automatic logic [ID_W-1:0] own_like();
    logic [OWN_W-1:0] base;
    case ($urandom_range(2))
      0:       base = OWN_W'(cur_own / 100);
      1:       base = OWN_W'(cur_own / 10);
      default: base = cur_own;
    endcase
    if ($urandom_range(3) == 0) base = base + OWN_W'($urandom_range(1));
    return base[ID_W-1:0];
  endfunction

  function automatic logic [ID_W-1:0] pick_src();
    if (cur_self && $urandom_range(1) == 0) return own_like();
    case ($urandom_range(9))
      0:       return rand_id24();
      1, 2, 3: return pick_loaded(SEL_ALLOWED, rand_radio_id());
      4:       return pick_loaded(SEL_BLOCKED, rand_radio_id());
      5:       return ID_W'(pick_loaded(SEL_PREFIX, ID_W'($urandom_range(999, 1))) * 10000
                      + $urandom_range(9999));
      6:       return own_like();
      default: return rand_radio_id();
    endcase
  endfunction

  function automatic logic [ID_W-1:0] pick_dest();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r <= 3) return pick_loaded(SEL_SLOT_ONE, rand_group());
    if (r <= 6) return pick_loaded(SEL_SLOT_TWO, rand_group());
    return rand_group();
  endfunction

  task automatic push_item(logic [1:0] cmd, logic [2:0] sel, logic [ID_W-1:0] entry,
                           logic [ID_W-1:0] src, logic [ID_W-1:0] dest,
                           logic [1:0] slt, logic grp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    list_select <= sel;
    entry_value <= entry;
    src_id <= src;
    dest_id <= dest;
    slot <= slt;
    group_call <= grp;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_CLEAR) foreach (loaded[i]) loaded[i].delete();
    if (cmd == CMD_APPEND && sel < NUM_LISTS) loaded[sel].push_back(entry);
  endtask

  task automatic append_entry(logic [2:0] sel, logic [ID_W-1:0] value);
    push_item(CMD_APPEND, sel, value, rand_id24(), rand_id24(), 2'($urandom_range(3)),
              1'($urandom_range(1)));
  endtask

  task automatic check_ids(logic [ID_W-1:0] src, logic [ID_W-1:0] dest,
                           logic [1:0] slt, logic grp);
    push_item(CMD_CHECK, 3'($urandom_range(7)), rand_id24(), src, dest, slt, grp);
  endtask

  task automatic clear_lists();
    push_item(CMD_CLEAR, 3'($urandom_range(7)), rand_id24(), rand_id24(), rand_id24(),
              2'($urandom_range(3)), 1'($urandom_range(1)));
  endtask

  // registers only change once the block has drained
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [OWN_W-1:0] data);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_block(int blk, int n);
    int done;
    int r;
    logic [2:0] sel;
    logic [1:0] cmd;
    done = 1;
    clear_lists();
    // walk one list past full now and then
    if (blk == 1 || $urandom_range(3) == 0) begin
      sel = 3'($urandom_range(NUM_LISTS - 1));
      repeat (LIST_DEPTH + $urandom_range(4, 1)) begin
        append_entry(sel, gen_entry(sel));
        done++;
      end
    end
    while (done < n) begin
      r = $urandom_range(99);
      if (r < 2) begin
        clear_lists();
        done++;
      end else if (r < 10) begin
        cmd = 2'($urandom_range(3));
        push_item(cmd, 3'($urandom_range(7)), rand_id24(), rand_id24(), rand_id24(),
                  2'($urandom_range(3)), 1'($urandom_range(1)));
        if (cmd != CMD_UNUSED) done++;
      end else if (r < 13) begin
        append_entry(3'($urandom_range(7, NUM_LISTS)), rand_id24());
        done++;
      end else if (r < 40) begin
        sel = 3'($urandom_range(NUM_LISTS - 1));
        append_entry(sel, gen_entry(sel));
        done++;
      end else begin
        check_ids(pick_src(), pick_dest(), 2'($urandom_range(3)), $urandom_range(3) != 0);
        done++;
      end
    end
  endtask

  int unsigned      idle_tab  [4] = '{0, 56, 0, 7};
  int unsigned      stall_tab [4] = '{0, 0, 56, 7};
  logic             self_tab  [BLOCKS] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
  logic [OWN_W-1:0] own_tab   [BLOCKS];

  initial begin
    own_tab = '{30'd0, 30'd999999999, OWN_W'($urandom_range(999999999)), 30'd99999999,
                OWN_W'($urandom_range(999999999)), 30'd100000000, 30'd10000000,
                30'd9999999};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: prefix edges, empty lists, each list, ignored items, stale entries
    check_ids(24'd0, 24'd0, 2'd1, 1'b1);
    check_ids(24'd10000, 24'hFFFFFF, 2'd0, 1'b0);
    check_ids(24'd9999999, 24'hFFFFFF, 2'd2, 1'b1);
    check_ids(24'd10000000, 24'd1, 2'd3, 1'b1);
    check_ids(24'hFFFFFF, 24'd5, 2'd1, 1'b1);
    append_entry(SEL_BLOCKED, 24'd10000);
    append_entry(SEL_ALLOWED, 24'd9999999);
    append_entry(SEL_PREFIX, 24'd999);
    append_entry(SEL_PREFIX, 24'd1);
    append_entry(SEL_SLOT_ONE, 24'hFFFFFF);
    append_entry(SEL_SLOT_TWO, 24'd1);
    append_entry(3'd5, 24'd77);
    append_entry(3'd7, 24'hFFFFFF);
    push_item(CMD_UNUSED, SEL_PREFIX, 24'd5, 24'd10000, 24'd1, 2'd1, 1'b1);
    check_ids(24'd10000, 24'hFFFFFF, 2'd1, 1'b1);
    check_ids(24'd9999999, 24'd2, 2'd1, 1'b1);
    check_ids(24'd5550000, 24'd1, 2'd2, 1'b1);
    check_ids(24'd10001, 24'd1, 2'd0, 1'b1);
    clear_lists();
    check_ids(24'd10000, 24'd2, 2'd1, 1'b1);
    check_ids(24'd9999999, 24'hFFFFFF, 2'd2, 1'b1);

    for (int blk = 0; blk < BLOCKS; blk++) begin
      cur_self = self_tab[blk];
      cur_own = own_tab[blk];
      write_reg(CFG_SELF_ONLY, {{(OWN_W-1){1'b0}}, cur_self});
      write_reg(CFG_OWN_ID, cur_own);
      send_idle_pct = idle_tab[blk / 2];
      stall_pct = stall_tab[blk / 2];
      run_block(blk, BLOCK_ITEMS);
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (LIST_DEPTH + 16) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("radio_id_access_filter_core regression: pass");
    else
      $display("radio_id_access_filter_core regression: fail");
    $finish;
  end

endmodule
